FILE: design/bvbe_pkg.sv
// ----------------------------------------------------------------------------
// bvbe_pkg - shared types and helpers for the bit vector buffer engine
// Opcodes, register indexes, sequencer states and byte-wide bit helpers.
// ----------------------------------------------------------------------------
package bvbe_pkg;

	localparam int BUF_BYTES = 64;
	localparam int BYTE_AW   = 6;
	localparam int LEN_W     = 7;

	typedef enum logic [4:0] {
		OP_WRBYTE   = 5'd0,
		OP_RDBYTE   = 5'd1,
		OP_SHL      = 5'd2,
		OP_SHR      = 5'd3,
		OP_ROL      = 5'd4,
		OP_ROR      = 5'd5,
		OP_TEST     = 5'd6,
		OP_SET      = 5'd7,
		OP_INV      = 5'd8,
		OP_INVRANGE = 5'd9,
		OP_REVRANGE = 5'd10,
		OP_ALL      = 5'd11,
		OP_ANY      = 5'd12,
		OP_NONE     = 5'd13,
		OP_COUNT    = 5'd14,
		OP_FIRST    = 5'd15,
		OP_LASTIDX  = 5'd16,
		OP_BYTESWAP = 5'd17
	} op_t;

	typedef enum logic [1:0] {
		CFG_LENGTH = 2'd0,
		CFG_ORDER  = 2'd1,
		CFG_ENDIAN = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_RDW, S_MOD, S_MCHK, S_CPR, S_CPW, S_MVR, S_MVW,
		S_BWR, S_RGR, S_RGP, S_RGF, S_RVR, S_RVA, S_RVB, S_SWR, S_SWA, S_SWB,
		S_DONE
	} state_t;

	function automatic logic [7:0] bitrev8(input logic [7:0] x);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) r[i] = x[7-i];
		return r;
	endfunction

	function automatic logic [3:0] popcount8(input logic [7:0] x);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 8; i++) c = c + {3'd0, x[i]};
		return c;
	endfunction

	function automatic logic [2:0] lowest8(input logic [7:0] x);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 7; i >= 0; i--) if (x[i]) r = 3'(i);
		return r;
	endfunction

	function automatic logic [2:0] highest8(input logic [7:0] x);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 0; i < 8; i++) if (x[i]) r = 3'(i);
		return r;
	endfunction

endpackage

FILE: design/bit_vector_buffer_engine.sv
// ----------------------------------------------------------------------------
// bit_vector_buffer_engine - byte buffer seen as a configurable bit vector
// Byte access, shifts, rotates, single bit and bit range operations, range
// queries and byte order reversal, sequenced over a byte-wide buffer RAM.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat fields (lowest bit first)
// s_*       in   opcode, first_index, last_index, range_to_end, amount,
//                bit_value, relative, byte_in
// m_*       out  result_value, result_flag, status
// cfg_*     in   cfg_index selects the register, cfg_data carries the value
//
// Shifts and rotates copy the buffer to scratch, then rebuild each byte from
// two scratch reads; a rotate first reduces its distance. Range ops visit
// each byte of the range, bit range reversal swaps one bit pair at a time and
// byte swap one byte pair at a time. The buffer RAM has a single write port
// and needs no clearing pass after reset. Input is taken only while idle; a
// finished result waits in the output register and a stalled m_tready holds
// the sequencer at its end.
// ----------------------------------------------------------------------------
module bit_vector_buffer_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[4:0] first_index[13:5] last_index[22:14] range_to_end[23]
	// amount[35:24] bit_value[36] relative[37] byte_in[45:38], zero above
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_value[9:0] result_flag[10] status[12:11], zero above
	output logic [15:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import bvbe_pkg::*;

	// configuration
	logic [LEN_W-1:0] len_q;
	logic             indep_q;
	logic             be_q;

	state_t state_q, state_d;

	// item fields held for the whole operation; a rotate reduces amt_q in place
	logic [4:0]  op_q;
	logic [8:0]  first_q;
	logic [8:0]  last_q;
	logic        rok_q;
	logic [11:0] amt_q;
	logic        bitv_q;
	logic        rel_q;
	logic [7:0]  byte_q;

	// sequencer work registers
	logic [3:0]  modb_q;
	logic        fillall_q;
	logic [6:0]  k_q;
	logic [8:0]  a_q, b_q;
	logic [9:0]  cnt_q;
	logic [7:0]  hold_q;
	logic        v0_q, v1_q;

	// result being built and the output register
	logic [9:0]  rval_q;
	logic        rflag_q;
	logic [1:0]  rstat_q;
	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;

	// memories
	logic        buf_we, scr_we;
	logic [5:0]  buf_wa, buf_ra0, buf_ra1, scr_wa, scr_ra0, scr_ra1;
	logic [7:0]  buf_wd, scr_wd, buf_rd0, buf_rd1, scr_rd0, scr_rd1;

	// effective length
	logic [6:0] nb;
	logic [9:0] lbits;

	always_comb begin
		if (len_q == 7'd0) nb = 7'd1;
		else if (len_q > 7'(BUF_BYTES)) nb = 7'(BUF_BYTES);
		else nb = len_q;
	end
	assign lbits = {nb, 3'b000};

	// logical byte k to its place in the RAM
	function automatic logic [5:0] phys_f(input logic [6:0] k);
		logic [6:0] t;
		t = (!indep_q && be_q) ? (nb - 7'd1 - k) : k;
		return t[5:0];
	endfunction

	// logical bit j within a byte to its physical bit
	function automatic logic [2:0] pos_f(input logic [2:0] j);
		return indep_q ? ~j : j;
	endfunction

	// swap between physical and logical bit order (its own inverse)
	function automatic logic [7:0] lswap_f(input logic [7:0] x);
		return indep_q ? bitrev8(x) : x;
	endfunction

	// decode of the incoming beat
	logic [8:0] in_first, in_last, in_last_eff;
	assign in_first    = s_tdata[13:5];
	assign in_last     = s_tdata[22:14];
	assign in_last_eff = s_tdata[23] ? 9'(lbits - 10'd1) : in_last;

	logic accept;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// distance reduction compare and subtract
	logic [18:0] mod_div;
	logic        mod_ge;
	assign mod_div = {9'd0, lbits} << modb_q;
	assign mod_ge  = {7'd0, amt_q} >= mod_div;

	// direction of a shift or rotate in logical bit order
	logic up, is_rot;
	assign is_rot = (op_q == OP_ROL) || (op_q == OP_ROR);
	assign up     = ((op_q == OP_SHL) || (op_q == OP_ROL)) ? !indep_q : indep_q;

	// source logical bytes for one rebuilt byte
	logic [7:0] src0, src1, src0w, src1w;
	logic       s0ok, s1ok;
	always_comb begin
		if (up) begin
			src0 = {1'b0, k_q} - {1'b0, amt_q[9:3]};
			src1 = src0 - 8'd1;
			s0ok = !src0[7];
			s1ok = !src1[7];
			src0w = s0ok ? src0 : src0 + {1'b0, nb};
			src1w = s1ok ? src1 : src1 + {1'b0, nb};
		end else begin
			src0 = {1'b0, k_q} + {1'b0, amt_q[9:3]};
			src1 = src0 + 8'd1;
			s0ok = src0 < {1'b0, nb};
			s1ok = src1 < {1'b0, nb};
			src0w = s0ok ? src0 : src0 - {1'b0, nb};
			src1w = s1ok ? src1 : src1 - {1'b0, nb};
		end
	end

	// rebuilt byte
	logic [7:0]  fillb, o0, o1, mv_new;
	logic [15:0] mv_up, mv_dn;
	assign fillb = {8{bitv_q}};
	assign o0    = v0_q ? lswap_f(scr_rd0) : fillb;
	assign o1    = v1_q ? lswap_f(scr_rd1) : fillb;
	assign mv_up = {o0, o1} << amt_q[2:0];
	assign mv_dn = {o1, o0} >> amt_q[2:0];
	assign mv_new = fillall_q ? fillb : (up ? mv_up[15:8] : mv_dn[7:0]);

	// range byte mask and scan
	logic [2:0] rlo, rhi;
	logic [7:0] rmask, rlog, rm;
	logic [3:0] rpc;
	logic       at_f8, at_l8;
	logic [8:0] fidx;
	assign at_f8 = (k_q == {1'b0, first_q[8:3]});
	assign at_l8 = (k_q == {1'b0, last_q[8:3]});
	assign rlo   = at_f8 ? first_q[2:0] : 3'd0;
	assign rhi   = at_l8 ? last_q[2:0] : 3'd7;
	assign rmask = (8'hFF << rlo) & (8'hFF >> (3'd7 - rhi));
	assign rlog  = lswap_f(buf_rd0);
	assign rm    = rlog & rmask;
	assign rpc   = popcount8(rm);
	assign fidx  = {k_q[5:0], (op_q == OP_LASTIDX) ? highest8(rm) : lowest8(rm)};

	// single bit and reversal helpers
	logic [2:0] pa, pb, pf;
	logic       bit_a, bit_b;
	logic [7:0] bwr_byte, rva_byte, rvb_byte;
	assign pf    = pos_f(first_q[2:0]);
	assign pa    = pos_f(a_q[2:0]);
	assign pb    = pos_f(b_q[2:0]);
	assign bit_a = buf_rd0[pa];
	assign bit_b = buf_rd1[pb];
	always_comb begin
		bwr_byte = buf_rd0;
		bwr_byte[pf] = (op_q == OP_SET) ? bitv_q : ~buf_rd0[pf];
		rva_byte = buf_rd0;
		rva_byte[pa] = bit_b;
		if (a_q[8:3] == b_q[8:3]) rva_byte[pb] = bit_a;
		rvb_byte = buf_rd1;
		rvb_byte[pb] = bit_a;
	end

	logic [6:0] swap_hi;
	assign swap_hi = nb - 7'd1 - k_q;

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// next state and memory control
	always_comb begin
		state_d = state_q;
		buf_we = 1'b0; buf_wa = 6'd0; buf_wd = 8'd0;
		buf_ra0 = 6'd0; buf_ra1 = 6'd0;
		scr_we = 1'b0; scr_wa = 6'd0; scr_wd = 8'd0;
		scr_ra0 = 6'd0; scr_ra1 = 6'd0;
		unique case (state_q)
			S_IDLE: if (accept) state_d = S_DISP;
			S_DISP: begin
				unique case (op_q)
					OP_WRBYTE: begin
						buf_we = ({2'b00, nb} > first_q);
						buf_wa = first_q[5:0];
						buf_wd = byte_q;
						state_d = S_DONE;
					end
					OP_RDBYTE: begin
						buf_ra0 = first_q[5:0];
						state_d = ({2'b00, nb} > first_q) ? S_RDW : S_DONE;
					end
					OP_SHL, OP_SHR: begin
						if ({2'b00, amt_q[11:3]} >= {4'd0, nb}) state_d = S_MVR;
						else if (amt_q == 12'd0) state_d = S_DONE;
						else state_d = S_CPR;
					end
					OP_ROL, OP_ROR: state_d = S_MOD;
					OP_TEST, OP_SET, OP_INV: begin
						buf_ra0 = phys_f({1'b0, first_q[8:3]});
						state_d = ({1'b0, first_q} < lbits) ? S_BWR : S_DONE;
					end
					OP_INVRANGE, OP_ALL, OP_ANY, OP_NONE, OP_COUNT, OP_FIRST,
					OP_LASTIDX:
						state_d = rok_q ? S_RGR : S_DONE;
					OP_REVRANGE: state_d = rok_q ? S_RVR : S_DONE;
					OP_BYTESWAP: state_d = S_SWR;
					default: state_d = S_DONE;
				endcase
			end
			S_RDW: state_d = S_DONE;
			S_MOD: if (modb_q == 4'd0) state_d = S_MCHK;
			S_MCHK: state_d = (amt_q == 12'd0) ? S_DONE : S_CPR;
			S_CPR: begin
				buf_ra0 = k_q[5:0];
				state_d = S_CPW;
			end
			S_CPW: begin
				scr_we = 1'b1; scr_wa = k_q[5:0]; scr_wd = buf_rd0;
				state_d = (k_q == nb - 7'd1) ? S_MVR : S_CPR;
			end
			S_MVR: begin
				scr_ra0 = phys_f(src0w[6:0]);
				scr_ra1 = phys_f(src1w[6:0]);
				state_d = S_MVW;
			end
			S_MVW: begin
				buf_we = 1'b1; buf_wa = phys_f(k_q); buf_wd = lswap_f(mv_new);
				state_d = (k_q == nb - 7'd1) ? S_DONE : S_MVR;
			end
			S_BWR: begin
				buf_we = (op_q != OP_TEST);
				buf_wa = phys_f({1'b0, first_q[8:3]});
				buf_wd = bwr_byte;
				state_d = S_DONE;
			end
			S_RGR: begin
				buf_ra0 = phys_f(k_q);
				state_d = S_RGP;
			end
			S_RGP: begin
				buf_we = (op_q == OP_INVRANGE);
				buf_wa = phys_f(k_q);
				buf_wd = lswap_f(rlog ^ rmask);
				priority if ((op_q == OP_FIRST || op_q == OP_LASTIDX) && rm != 8'd0)
					state_d = S_DONE;
				else if (op_q == OP_LASTIDX)
					state_d = at_f8 ? S_RGF : S_RGR;
				else
					state_d = at_l8 ? S_RGF : S_RGR;
			end
			S_RGF: state_d = S_DONE;
			S_RVR: begin
				buf_ra0 = phys_f({1'b0, a_q[8:3]});
				buf_ra1 = phys_f({1'b0, b_q[8:3]});
				state_d = (a_q < b_q) ? S_RVA : S_DONE;
			end
			S_RVA: begin
				buf_we = 1'b1; buf_wa = phys_f({1'b0, a_q[8:3]}); buf_wd = rva_byte;
				state_d = (a_q[8:3] == b_q[8:3]) ? S_RVR : S_RVB;
			end
			S_RVB: begin
				buf_we = 1'b1; buf_wa = phys_f({1'b0, b_q[8:3]}); buf_wd = hold_q;
				state_d = S_RVR;
			end
			S_SWR: begin
				buf_ra0 = k_q[5:0];
				buf_ra1 = swap_hi[5:0];
				state_d = (k_q < {1'b0, nb[6:1]}) ? S_SWA : S_DONE;
			end
			S_SWA: begin
				buf_we = 1'b1; buf_wa = k_q[5:0]; buf_wd = buf_rd1;
				state_d = S_SWB;
			end
			S_SWB: begin
				buf_we = 1'b1; buf_wa = swap_hi[5:0]; buf_wd = hold_q;
				state_d = S_SWR;
			end
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers; the sender writes them only between items (a rule for the sender, not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= 7'(BUF_BYTES);
			indep_q <= 1'b0;
			be_q    <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LENGTH: len_q   <= cfg_data;
				CFG_ORDER:  indep_q <= cfg_data[0];
				CFG_ENDIAN: be_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// output register: hold the result until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free)
			m_tdata_q <= {3'd0, rstat_q, rflag_q, rval_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (accept) begin
				op_q    <= s_tdata[4:0];
				first_q <= in_first;
				last_q  <= in_last_eff;
				rok_q   <= (in_first <= in_last_eff) && ({1'b0, in_last_eff} < lbits);
				amt_q   <= s_tdata[35:24];
				bitv_q  <= s_tdata[36];
				rel_q   <= s_tdata[37];
				byte_q  <= s_tdata[45:38];
				rval_q  <= 10'd0;
				rflag_q <= 1'b0;
				rstat_q <= ST_OK;
				cnt_q   <= 10'd0;
				modb_q  <= 4'd9;
				fillall_q <= 1'b0;
			end
			S_DISP: begin
				a_q <= first_q;
				b_q <= last_q;
				// range scans start at the byte of their first visited bit
				priority if (op_q == OP_LASTIDX)
					k_q <= {1'b0, last_q[8:3]};
				else if (op_q >= OP_INVRANGE && op_q <= OP_FIRST)
					k_q <= {1'b0, first_q[8:3]};
				else
					k_q <= 7'd0;
				unique case (op_q)
					OP_WRBYTE, OP_RDBYTE:
						if ({2'b00, nb} <= first_q) rstat_q <= ST_INVALID;
					OP_SHL, OP_SHR:
						fillall_q <= ({2'b00, amt_q[11:3]} >= {4'd0, nb});
					OP_ROL, OP_ROR: ;
					OP_TEST, OP_SET, OP_INV:
						if ({1'b0, first_q} >= lbits) rstat_q <= ST_INVALID;
					OP_INVRANGE, OP_ALL, OP_ANY, OP_NONE, OP_COUNT, OP_FIRST,
					OP_LASTIDX, OP_REVRANGE: begin
						if (!rok_q) rstat_q <= ST_INVALID;
						else if (op_q == OP_FIRST || op_q == OP_LASTIDX)
							rstat_q <= ST_NOTFOUND;
					end
					OP_BYTESWAP: ;
					default: rstat_q <= ST_INVALID;
				endcase
			end
			S_RDW: rval_q <= {2'b00, buf_rd0};
			S_MOD: begin
				if (mod_ge) amt_q <= 12'({7'd0, amt_q} - mod_div);
				modb_q <= modb_q - 4'd1;
			end
			S_CPW: k_q <= (k_q == nb - 7'd1) ? 7'd0 : k_q + 7'd1;
			S_MVR: begin
				v0_q <= s0ok || is_rot;
				v1_q <= s1ok || is_rot;
			end
			S_MVW: k_q <= k_q + 7'd1;
			S_BWR: if (op_q == OP_TEST) rflag_q <= buf_rd0[pf];
			S_RGP: begin
				cnt_q <= cnt_q + {6'd0, rpc};
				if ((op_q == OP_FIRST || op_q == OP_LASTIDX) && rm != 8'd0) begin
					rval_q  <= {1'b0, rel_q ? fidx - first_q : fidx};
					rstat_q <= ST_OK;
				end
				if (op_q == OP_LASTIDX) k_q <= k_q - 7'd1;
				else k_q <= k_q + 7'd1;
			end
			S_RGF: begin
				unique case (op_q)
					OP_ALL:   rflag_q <= (cnt_q == {1'b0, last_q - first_q} + 10'd1);
					OP_ANY:   rflag_q <= (cnt_q != 10'd0);
					OP_NONE:  rflag_q <= (cnt_q == 10'd0);
					OP_COUNT: rval_q  <= cnt_q;
					default: ;
				endcase
			end
			S_RVA: hold_q <= rvb_byte;
			S_RVB: ;
			S_SWA: hold_q <= buf_rd0;
			S_SWB: k_q <= k_q + 7'd1;
			default: ;
		endcase
		if ((state_q == S_RVA && a_q[8:3] == b_q[8:3]) || state_q == S_RVB) begin
			a_q <= a_q + 9'd1;
			b_q <= b_q - 9'd1;
		end
	end

	bvbe_ram #(.W(8), .D(BUF_BYTES)) u_buf (
		.clk(clk), .we(buf_we), .waddr(buf_wa), .wdata(buf_wd),
		.raddr0(buf_ra0), .raddr1(buf_ra1), .rdata0(buf_rd0), .rdata1(buf_rd1)
	);

	bvbe_ram #(.W(8), .D(BUF_BYTES)) u_scratch (
		.clk(clk), .we(scr_we), .waddr(scr_wa), .wdata(scr_wd),
		.raddr0(scr_ra0), .raddr1(scr_ra1), .rdata0(scr_rd0), .rdata1(scr_rd1)
	);

	// a result in the done state with a free output register is loaded and the sequencer returns to idle
	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !m_tvalid_q) |=> (m_tvalid_q && state_q == S_IDLE))
		else $error("result not loaded from done state");

	// distance reduction never grows the distance
	a_mod_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD) |=> (amt_q <= $past(amt_q)))
		else $error("distance grew during reduction");

	// the copy phase only starts with a distance below the bit length
	a_copy_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CPR) |-> ({2'b00, amt_q[9:0]} < {2'b00, lbits} && amt_q[11:10] == 2'b00))
		else $error("copy phase entered with distance out of range");

	// rebuild index stays inside the buffer
	a_move_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MVR || state_q == S_MVW) |-> (k_q < nb))
		else $error("rebuild byte index beyond length");

	// scratch is written only by the copy phase
	a_scr_we: assert property (@(posedge clk) disable iff (!arst_n)
		scr_we |-> (state_q == S_CPW))
		else $error("scratch written outside copy phase");

endmodule

FILE: design/bvbe_ram.sv
// ----------------------------------------------------------------------------
// bvbe_ram - generic RAM, one write port, two registered read ports
// ----------------------------------------------------------------------------
module bvbe_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr0,
	input  logic [$clog2(D)-1:0] raddr1,
	output logic [W-1:0]         rdata0,
	output logic [W-1:0]         rdata1
);
	logic [W-1:0] mem_q [D];
	logic [W-1:0] rd0_q;
	logic [W-1:0] rd1_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rd0_q <= mem_q[raddr0];
		rd1_q <= mem_q[raddr1];
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;
endmodule
